// ===== hdl/pts_pkg.sv =====
package pts_pkg;

  localparam int PRIO_W = 8;
  localparam int ID_W   = 32;

  // Operation codes on opcode_i
  typedef enum logic [2:0] {
    OP_CREATE   = 3'd0,
    OP_SCHEDULE = 3'd1,
    OP_BLOCK    = 3'd2,
    OP_WAKEUP   = 3'd3,
    OP_EXIT     = 3'd4
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STS_OK         = 2'd0,
    STS_FULL       = 2'd1,
    STS_NO_CURRENT = 2'd2,
    STS_EMPTY_SLOT = 2'd3
  } status_e;

  // Per-slot task state
  typedef enum logic [1:0] {
    SS_READY   = 2'd0,
    SS_RUNNING = 2'd1,
    SS_BLOCKED = 2'd2
  } slot_state_e;

  // Write commands broadcast to the slot cells
  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_SETST  = 2'd2,
    CMD_FREE   = 2'd3
  } cmd_e;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_SEED = 3'd1,
    S_WAIT = 3'd2,
    S_EXEC = 3'd3,
    S_FIN  = 3'd4
  } fsm_e;

  // Command to the cells (slot index travels on its own port)
  typedef struct packed {
    cmd_e              code;
    slot_state_e       state;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } cmd_t;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic              found;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic              free_found;
    logic              tgt_used;
    slot_state_e       tgt_state;
  } scan_t;

endpackage

// ===== hdl/pts_cell.sv =====
module pts_cell import pts_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  parameter int CELL_IDX  = 0,
  localparam int SLOT_W   = $clog2(NUM_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  input  logic [SLOT_W-1:0] cmd_idx_i,
  input  logic              excl_en_i,
  input  logic [SLOT_W-1:0] excl_idx_i,
  input  logic [SLOT_W-1:0] tgt_idx_i,
  input  scan_t             scan_i,
  input  logic [SLOT_W-1:0] best_idx_i,
  input  logic [SLOT_W-1:0] free_idx_i,
  output scan_t             scan_o,
  output logic [SLOT_W-1:0] best_idx_o,
  output logic [SLOT_W-1:0] free_idx_o
);

  localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

  logic              used_q;
  slot_state_e       state_q;
  logic [PRIO_W-1:0] prio_q;
  logic [ID_W-1:0]   id_q;

  scan_t             scan_d, scan_q;
  logic [SLOT_W-1:0] best_idx_d, best_idx_q;
  logic [SLOT_W-1:0] free_idx_d, free_idx_q;

  logic cand, better, hit;

  // Slot contents; slot 0 holds the idle task after reset
  assign hit = (cmd_i.code != CMD_NONE) && (cmd_idx_i == MY_IDX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= (CELL_IDX == 0);
      state_q <= (CELL_IDX == 0) ? SS_RUNNING : SS_READY;
      prio_q  <= '0;
      id_q    <= (CELL_IDX == 0) ? ID_W'(1) : '0;
    end else if (hit) begin
      case (cmd_i.code)
        CMD_CREATE: begin
          used_q  <= 1'b1;
          state_q <= SS_READY;
          prio_q  <= cmd_i.prio;
          id_q    <= cmd_i.id;
        end
        CMD_SETST: state_q <= cmd_i.state;
        CMD_FREE: begin
          used_q  <= 1'b0;
          state_q <= SS_READY;
        end
        default: ;
      endcase
    end
  end

  // Merge this slot into the passing scan token
  always_comb begin
    cand = used_q && (state_q == SS_READY) && !(excl_en_i && (excl_idx_i == MY_IDX));
    better = !scan_i.found || (prio_q > scan_i.prio) ||
             ((prio_q == scan_i.prio) && (id_q < scan_i.id));
    scan_d     = scan_i;
    best_idx_d = best_idx_i;
    free_idx_d = free_idx_i;
    if (cand && better) begin
      scan_d.found = 1'b1;
      scan_d.prio  = prio_q;
      scan_d.id    = id_q;
      best_idx_d   = MY_IDX;
    end
    if (!scan_i.free_found && !used_q) begin
      scan_d.free_found = 1'b1;
      free_idx_d        = MY_IDX;
    end
    if (tgt_idx_i == MY_IDX) begin
      scan_d.tgt_used  = used_q;
      scan_d.tgt_state = state_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q     <= '0;
      best_idx_q <= '0;
      free_idx_q <= '0;
    end else begin
      scan_q     <= scan_d;
      best_idx_q <= best_idx_d;
      free_idx_q <= free_idx_d;
    end
  end

  assign scan_o     = scan_q;
  assign best_idx_o = best_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

// ===== hdl/pts_ctrl.sv =====
module pts_ctrl import pts_pkg::*; #(
  parameter int NUM_SLOTS = 16,
  localparam int SLOT_W   = $clog2(NUM_SLOTS)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        opcode_i,
  input  logic [PRIO_W-1:0] task_priority_i,
  input  logic [3:0]        target_slot_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [3:0]        current_slot_o,
  output logic              current_valid_o,
  output logic [ID_W-1:0]   result_id_o,
  output logic              switched_o,
  // cell chain
  output cmd_t              cmd_o,
  output logic [SLOT_W-1:0] cmd_idx_o,
  output logic              excl_en_o,
  output logic [SLOT_W-1:0] excl_idx_o,
  output logic [SLOT_W-1:0] tgt_idx_o,
  output scan_t             seed_o,
  input  scan_t             scan_i,
  input  logic [SLOT_W-1:0] best_idx_i,
  input  logic [SLOT_W-1:0] free_idx_i
);

  fsm_e              state_d, state_q;
  logic [2:0]        op_d, op_q;
  logic [PRIO_W-1:0] prio_d, prio_q;
  logic [3:0]        tgt_d, tgt_q;

  // Current task tracking
  logic [SLOT_W-1:0] rs_d, rs_q;
  logic              rv_d, rv_q;
  logic [ID_W-1:0]   rid_d, rid_q;
  slot_state_e       rstate_d, rstate_q;
  logic [ID_W-1:0]   idc_d, idc_q;

  // Latched scan result
  scan_t             sres_d, sres_q;
  logic [SLOT_W-1:0] bidx_d, bidx_q;
  logic [SLOT_W-1:0] fidx_d, fidx_q;

  // Per-transaction outcome
  logic              pend_d, pend_q;
  logic [SLOT_W-1:0] pidx_d, pidx_q;
  status_e           sts_d, sts_q;
  logic              created_d, created_q;
  logic [ID_W-1:0]   newid_d, newid_q;
  logic              sw_d, sw_q;

  // Result registers
  logic              done_d, done_q;
  status_e           res_sts_d, res_sts_q;
  logic [3:0]        res_slot_d, res_slot_q;
  logic              res_cv_d, res_cv_q;
  logic [ID_W-1:0]   res_id_d, res_id_q;
  logic              res_sw_d, res_sw_q;

  logic [SLOT_W+3:0] tgt_ext;
  logic [SLOT_W+3:0] rs_ext;
  logic              tgt_in_range;
  logic              switch_ok;

  assign tgt_ext      = (SLOT_W+4)'(tgt_q);
  assign tgt_in_range = tgt_ext < (SLOT_W+4)'(NUM_SLOTS);
  assign tgt_idx_o    = tgt_ext[SLOT_W-1:0];
  assign excl_en_o    = (op_q == OP_BLOCK) || (op_q == OP_EXIT);
  assign excl_idx_o   = rs_q;
  assign switch_ok    = sres_q.found && !(rv_q && (bidx_q == rs_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rs_q     <= '0;
      rv_q     <= 1'b1;
      rid_q    <= ID_W'(1);
      rstate_q <= SS_RUNNING;
      idc_q    <= ID_W'(2);
      pend_q   <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rs_q     <= rs_d;
      rv_q     <= rv_d;
      rid_q    <= rid_d;
      rstate_q <= rstate_d;
      idc_q    <= idc_d;
      pend_q   <= pend_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    prio_q     <= prio_d;
    tgt_q      <= tgt_d;
    sres_q     <= sres_d;
    bidx_q     <= bidx_d;
    fidx_q     <= fidx_d;
    pidx_q     <= pidx_d;
    sts_q      <= sts_d;
    created_q  <= created_d;
    newid_q    <= newid_d;
    sw_q       <= sw_d;
    res_sts_q  <= res_sts_d;
    res_slot_q <= res_slot_d;
    res_cv_q   <= res_cv_d;
    res_id_q   <= res_id_d;
    res_sw_q   <= res_sw_d;
  end

  assign rs_ext = (SLOT_W+4)'(rs_q);

  // Next state, cell commands and result
  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    prio_d     = prio_q;
    tgt_d      = tgt_q;
    rs_d       = rs_q;
    rv_d       = rv_q;
    rid_d      = rid_q;
    rstate_d   = rstate_q;
    idc_d      = idc_q;
    sres_d     = sres_q;
    bidx_d     = bidx_q;
    fidx_d     = fidx_q;
    pend_d     = pend_q;
    pidx_d     = pidx_q;
    sts_d      = sts_q;
    created_d  = created_q;
    newid_d    = newid_q;
    sw_d       = sw_q;
    done_d     = 1'b0;
    res_sts_d  = res_sts_q;
    res_slot_d = res_slot_q;
    res_cv_d   = res_cv_q;
    res_id_d   = res_id_q;
    res_sw_d   = res_sw_q;
    busy_o     = (state_q != S_IDLE);
    seed_o     = '0;
    cmd_o      = '0;
    cmd_idx_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d    = opcode_i;
          prio_d  = task_priority_i;
          tgt_d   = target_slot_i;
          state_d = S_SEED;
        end
      end

      // Launch one token into the chain
      S_SEED: begin
        seed_o.vld = 1'b1;
        state_d    = S_WAIT;
      end

      S_WAIT: begin
        if (scan_i.vld) begin
          sres_d  = scan_i;
          bidx_d  = best_idx_i;
          fidx_d  = free_idx_i;
          state_d = S_EXEC;
        end
      end

      // Apply the operation; a second slot write may be left pending
      S_EXEC: begin
        pend_d    = 1'b0;
        sts_d     = STS_OK;
        created_d = 1'b0;
        sw_d      = 1'b0;
        unique case (op_q)
          OP_CREATE: begin
            if (sres_q.free_found) begin
              cmd_o.code = CMD_CREATE;
              cmd_o.prio = prio_q;
              cmd_o.id   = idc_q;
              cmd_idx_o  = fidx_q;
              newid_d    = idc_q;
              idc_d      = idc_q + ID_W'(1);
              created_d  = 1'b1;
            end else begin
              sts_d = STS_FULL;
            end
          end
          OP_SCHEDULE: begin
            if (switch_ok) begin
              if (rv_q && (rstate_q == SS_RUNNING)) begin
                cmd_o.code  = CMD_SETST;
                cmd_o.state = SS_READY;
                cmd_idx_o   = rs_q;
              end
              pend_d   = 1'b1;
              pidx_d   = bidx_q;
              rs_d     = bidx_q;
              rv_d     = 1'b1;
              rid_d    = sres_q.id;
              rstate_d = SS_RUNNING;
              sw_d     = 1'b1;
            end
          end
          OP_BLOCK: begin
            if (!rv_q) begin
              sts_d = STS_NO_CURRENT;
            end else begin
              cmd_o.code  = CMD_SETST;
              cmd_o.state = SS_BLOCKED;
              cmd_idx_o   = rs_q;
              rstate_d    = SS_BLOCKED;
              if (sres_q.found) begin
                pend_d   = 1'b1;
                pidx_d   = bidx_q;
                rs_d     = bidx_q;
                rid_d    = sres_q.id;
                rstate_d = SS_RUNNING;
                sw_d     = 1'b1;
              end
            end
          end
          OP_WAKEUP: begin
            if (!tgt_in_range || !sres_q.tgt_used) begin
              sts_d = STS_EMPTY_SLOT;
            end else if (sres_q.tgt_state == SS_BLOCKED) begin
              cmd_o.code  = CMD_SETST;
              cmd_o.state = SS_READY;
              cmd_idx_o   = tgt_idx_o;
              if (rv_q && (tgt_idx_o == rs_q)) begin
                rstate_d = SS_READY;
              end
            end
          end
          OP_EXIT: begin
            if (!rv_q) begin
              sts_d = STS_NO_CURRENT;
            end else begin
              cmd_o.code = CMD_FREE;
              cmd_idx_o  = rs_q;
              rv_d       = 1'b0;
              rs_d       = '0;
              rid_d      = '0;
              sw_d       = 1'b1;
              if (sres_q.found) begin
                pend_d   = 1'b1;
                pidx_d   = bidx_q;
                rs_d     = bidx_q;
                rv_d     = 1'b1;
                rid_d    = sres_q.id;
                rstate_d = SS_RUNNING;
              end
            end
          end
          default: ;
        endcase
        state_d = S_FIN;
      end

      // Pending promotion to running, then publish the result
      S_FIN: begin
        if (pend_q) begin
          cmd_o.code  = CMD_SETST;
          cmd_o.state = SS_RUNNING;
          cmd_idx_o   = pidx_q;
        end
        pend_d     = 1'b0;
        done_d     = 1'b1;
        res_sts_d  = sts_q;
        res_cv_d   = rv_q;
        res_slot_d = rv_q ? rs_ext[3:0] : 4'd0;
        res_sw_d   = sw_q;
        if (created_q) begin
          res_id_d = newid_q;
        end else if (sts_q == STS_FULL) begin
          res_id_d = '0;
        end else begin
          res_id_d = rv_q ? rid_q : '0;
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign done_o          = done_q;
  assign status_o        = res_sts_q;
  assign current_slot_o  = res_slot_q;
  assign current_valid_o = res_cv_q;
  assign result_id_o     = res_id_q;
  assign switched_o      = res_sw_q;

endmodule

// ===== hdl/priority_task_scheduler_top.sv =====
// Static-priority task scheduler.
// Command channel: drive opcode_i, task_priority_i and target_slot_i with
// start_i; the transaction is taken at a clock edge where start_i is high and
// busy_o is low. Inputs are captured then and need not be held.
// Result channel: done_o is high for exactly one cycle with status_o,
// current_slot_o, current_valid_o, result_id_o and switched_o valid. The
// receiver cannot stall; the result ports hold their value until the next one.
// Every slot is a cell in a chain; one scan token walks the chain one cell per
// cycle, finding the best ready task, the lowest free slot and the wakeup
// target. An operation passes from accept through the S_SEED, S_WAIT, S_EXEC and
// S_FIN states to done_o, waiting in S_WAIT for the token's walk through the
// chain; a new command is accepted in the cycle done_o is high, not earlier.
// Reset (rst_ni low, asynchronous) leaves the idle task in slot 0 running with
// id 1, all other slots empty and the next id at 2. No clearing pass is needed.
module priority_task_scheduler_top import pts_pkg::*; #(
  parameter int NUM_SLOTS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [2:0]        opcode_i,
  input  logic [PRIO_W-1:0] task_priority_i,
  input  logic [3:0]        target_slot_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [3:0]        current_slot_o,
  output logic              current_valid_o,
  output logic [ID_W-1:0]   result_id_o,
  output logic              switched_o
);

  localparam int SLOT_W = $clog2(NUM_SLOTS);

  cmd_t              cmd;
  logic [SLOT_W-1:0] cmd_idx;
  logic              excl_en;
  logic [SLOT_W-1:0] excl_idx;
  logic [SLOT_W-1:0] tgt_idx;

  scan_t             chain    [NUM_SLOTS+1];
  logic [SLOT_W-1:0] best_idx [NUM_SLOTS+1];
  logic [SLOT_W-1:0] free_idx [NUM_SLOTS+1];

  assign best_idx[0] = '0;
  assign free_idx[0] = '0;

  pts_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .opcode_i        (opcode_i),
    .task_priority_i (task_priority_i),
    .target_slot_i   (target_slot_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .current_slot_o  (current_slot_o),
    .current_valid_o (current_valid_o),
    .result_id_o     (result_id_o),
    .switched_o      (switched_o),
    .cmd_o           (cmd),
    .cmd_idx_o       (cmd_idx),
    .excl_en_o       (excl_en),
    .excl_idx_o      (excl_idx),
    .tgt_idx_o       (tgt_idx),
    .seed_o          (chain[0]),
    .scan_i          (chain[NUM_SLOTS]),
    .best_idx_i      (best_idx[NUM_SLOTS]),
    .free_idx_i      (free_idx[NUM_SLOTS])
  );

  // Row of slot cells, token flows from slot 0 upward
  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    pts_cell #(
      .NUM_SLOTS (NUM_SLOTS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .cmd_idx_i  (cmd_idx),
      .excl_en_i  (excl_en),
      .excl_idx_i (excl_idx),
      .tgt_idx_i  (tgt_idx),
      .scan_i     (chain[g]),
      .best_idx_i (best_idx[g]),
      .free_idx_i (free_idx[g]),
      .scan_o     (chain[g+1]),
      .best_idx_o (best_idx[g+1]),
      .free_idx_o (free_idx[g+1])
    );
  end

endmodule
